>>> design/hdlc_dfr_pkg.sv
// ----------------------------------------------------------------------------
// HDLC deframer package
// Shared constants, the event code type and the result record of the
// HDLC bit deframer.
// ----------------------------------------------------------------------------
package hdlc_dfr_pkg;

  localparam int MaxFrame = 256;
  localparam int ByteCntW = $clog2(MaxFrame + 1);
  localparam int LenW     = 9;
  localparam int MaxRes   = 4;

  localparam logic [2:0] OnesStuff = 3'd5;
  localparam logic [2:0] OnesFlag  = 3'd6;
  localparam logic [2:0] OnesAbort = 3'd7;

  typedef enum logic [1:0] {
    EvData  = 2'd0,
    EvEnd   = 2'd1,
    EvAbort = 2'd2
  } event_e;

  typedef struct packed {
    event_e          ev;
    logic [7:0]      data;
    logic [LenW-1:0] len;
    logic            ovf;
    logic [2:0]      resid;
  } res_t;

endpackage

>>> design/hdlc_bit_deframer.sv
// ----------------------------------------------------------------------------
// HDLC bit deframer
// Finds flags, removes stuffed zeros and detects aborts in a byte stream,
// giving decoded bytes, frame end and abort items.
// ----------------------------------------------------------------------------
// The slave channel takes one received byte per item, bits taken most
// significant first. The master channel gives one result item per handshake:
// tuser carries the event (data byte, frame end, abort inside a frame), tdata
// the byte or the frame end figures, and tlast marks the final result caused
// by one input byte. A byte that causes no result gives no item.
// An input byte is held in an input register; once the result buffer is free,
// its eight bit steps are resolved in one pass and its up to four results are
// loaded into that buffer, from which one item leaves per cycle while the
// receiver is ready. A byte is taken every cycle while each byte causes at
// most one result and the receiver is ready; a byte with more results holds
// back the next byte until its last item is taken. When the receiver stalls,
// the buffer holds and the input register fills, after which tready drops.
// Reset clears all decoder state: the block starts hunting for a flag with
// empty registers and no item on the master side.
// ----------------------------------------------------------------------------
module hdlc_bit_deframer
  import hdlc_dfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] data_byte, [16:8] frame_length,
                                      // [17] overflow, [20:18] residue_bits
  output logic [1:0]  m_axis_tuser,   // [1:0] event_res
  output logic        m_axis_tlast    // last
);

  logic                in_vld_q, in_vld_d;
  logic [7:0]          in_q;
  logic [2:0]          ones_q, ones_d;
  logic                held_q, held_d;
  logic                inside_q, inside_d;
  logic [7:0]          shift_q, shift_d;
  logic [2:0]          cnt_q, cnt_d;
  logic [ByteCntW-1:0] bcnt_q, bcnt_d;
  logic                ovf_q, ovf_d;
  res_t                res_q [MaxRes];
  res_t                res_d [MaxRes];
  logic [2:0]          n_d;
  logic [2:0]          rem_q, rem_d;
  logic [1:0]          idx_q, idx_d;
  logic                out_take, buf_free, process;
  res_t                head;

  function automatic res_t make_res(event_e ev, logic [7:0] data,
                                    logic [ByteCntW-1:0] len, logic ovf,
                                    logic [2:0] resid);
    res_t r;
    r.ev    = ev;
    r.data  = data;
    r.len   = LenW'(len);
    r.ovf   = ovf;
    r.resid = resid;
    return r;
  endfunction

  assign out_take      = m_axis_tvalid && m_axis_tready;
  assign buf_free      = (rem_q == 3'd0) || ((rem_q == 3'd1) && m_axis_tready);
  assign process       = in_vld_q && buf_free;
  assign s_axis_tready = !in_vld_q || process;

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_vld_d = 1'b1;
    end else if (process) begin
      in_vld_d = 1'b0;
    end
  end

  // Eight bit steps of one byte, resolved in a single pass.
  always_comb begin
    logic        b;
    logic [2:0]  k;
    logic [2:0]  m;
    logic [13:0] bits;
    logic [3:0]  total;
    logic [2:0]  left;
    logic [7:0]  byte_v;
    ones_d   = ones_q;
    held_d   = held_q;
    inside_d = inside_q;
    shift_d  = shift_q;
    cnt_d    = cnt_q;
    bcnt_d   = bcnt_q;
    ovf_d    = ovf_q;
    n_d      = 3'd0;
    k        = 3'd0;
    m        = 3'd0;
    bits     = '0;
    total    = '0;
    left     = '0;
    byte_v   = '0;
    for (int j = 0; j < MaxRes; j++) begin
      res_d[j] = res_q[j];
    end
    for (int i = 7; i >= 0; i--) begin
      b = in_q[i];
      if (b) begin
        if (ones_d < OnesFlag) begin
          ones_d = ones_d + 3'd1;
        end else if (ones_d == OnesFlag) begin
          if (inside_d && (n_d < 3'(MaxRes))) begin
            res_d[n_d[1:0]] = make_res(EvAbort, 8'd0, '0, 1'b0, 3'd0);
            n_d = n_d + 3'd1;
          end
          inside_d = 1'b0;
          shift_d  = '0;
          cnt_d    = '0;
          bcnt_d   = '0;
          ovf_d    = 1'b0;
          held_d   = 1'b0;
          ones_d   = OnesAbort;
        end
      end else begin
        if (ones_d == OnesFlag) begin
          if (inside_d && ((bcnt_d != '0) || (cnt_d != 3'd0) || ovf_d)
              && (n_d < 3'(MaxRes))) begin
            res_d[n_d[1:0]] = make_res(EvEnd, 8'd0, bcnt_d, ovf_d, cnt_d);
            n_d = n_d + 3'd1;
          end
          inside_d = 1'b1;
          shift_d  = '0;
          cnt_d    = '0;
          bcnt_d   = '0;
          ovf_d    = 1'b0;
          held_d   = 1'b0;
        end else if (ones_d == OnesAbort) begin
          held_d = 1'b1;
        end else begin
          // Commit the held zero and the run of ones as data bits.
          k = ones_d;
          m = {2'b00, held_d} + k;
          if (inside_d) begin
            bits  = ({6'd0, shift_d} << m) | 14'((6'd1 << k) - 6'd1);
            total = {1'b0, cnt_d} + {1'b0, m};
            if (total >= 4'd8) begin
              byte_v = 8'(bits >> (total - 4'd8));
              left   = 3'(total - 4'd8);
              if (bcnt_d < ByteCntW'(MaxFrame)) begin
                if (n_d < 3'(MaxRes)) begin
                  res_d[n_d[1:0]] = make_res(EvData, byte_v, '0, 1'b0, 3'd0);
                  n_d = n_d + 3'd1;
                end
                bcnt_d = bcnt_d + ByteCntW'(1);
              end else begin
                ovf_d = 1'b1;
              end
              cnt_d   = left;
              shift_d = 8'(bits) & 8'((9'd1 << left) - 9'd1);
            end else begin
              cnt_d   = total[2:0];
              shift_d = 8'(bits);
            end
          end
          held_d = (ones_d != OnesStuff);
        end
        ones_d = 3'd0;
      end
    end
  end

  always_comb begin
    rem_q_next_logic: begin
      rem_d = rem_q;
      idx_d = idx_q;
      if (out_take) begin
        rem_d = rem_q - 3'd1;
        idx_d = idx_q + 2'd1;
      end
      if (process && (n_d != 3'd0)) begin
        rem_d = n_d;
        idx_d = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      ones_q   <= '0;
      held_q   <= 1'b0;
      inside_q <= 1'b0;
      shift_q  <= '0;
      cnt_q    <= '0;
      bcnt_q   <= '0;
      ovf_q    <= 1'b0;
      rem_q    <= '0;
      idx_q    <= '0;
    end else begin
      in_vld_q <= in_vld_d;
      rem_q    <= rem_d;
      idx_q    <= idx_d;
      if (process) begin
        ones_q   <= ones_d;
        held_q   <= held_d;
        inside_q <= inside_d;
        shift_q  <= shift_d;
        cnt_q    <= cnt_d;
        bcnt_q   <= bcnt_d;
        ovf_q    <= ovf_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q <= s_axis_tdata;
    end
    if (process && (n_d != 3'd0)) begin
      for (int j = 0; j < MaxRes; j++) begin
        res_q[j] <= res_d[j];
      end
    end
  end

  assign head          = res_q[idx_q];
  assign m_axis_tvalid = (rem_q != 3'd0);
  assign m_axis_tlast  = (rem_q == 3'd1);
  assign m_axis_tuser  = head.ev;
  assign m_axis_tdata  = {3'd0, head.resid, head.ovf, head.len, head.data};

endmodule

>>> design/hdlc_dfr_checker.sv
// ----------------------------------------------------------------------------
// HDLC deframer checker
// Port-level assertions on the result channel of the HDLC bit deframer.
// ----------------------------------------------------------------------------
module hdlc_dfr_checker
  import hdlc_dfr_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("Stalled result item changed.");

  a_data_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == EvData) |-> (m_axis_tdata[23:8] == 16'd0))
    else $error("Data item carries frame end fields.");

  a_end_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == EvEnd) |->
      (m_axis_tdata[7:0] == 8'd0) && (m_axis_tdata[16:8] <= 9'(MaxFrame)))
    else $error("Frame end item malformed.");

  a_abort_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == EvAbort) |-> (m_axis_tdata == 24'd0))
    else $error("Abort item carries payload.");

  a_evt_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == EvData) || (m_axis_tuser == EvEnd)
      || (m_axis_tuser == EvAbort))
    else $error("Unknown event code on result item.");

endmodule

bind hdlc_bit_deframer hdlc_dfr_checker u_hdlc_dfr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
